FILE: src/transform_matrix_stack_defines.svh
// Assertion macros shared by the matrix stack RTL.
`ifndef TRANSFORM_MATRIX_STACK_DEFINES_SVH
`define TRANSFORM_MATRIX_STACK_DEFINES_SVH

`ifndef NO_ASSERTIONS
// condition must hold at every edge out of reset
`define TMS_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("matrix stack check failed");
// consequent must hold in the cycle after the antecedent
`define TMS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("matrix stack check failed");
`else
`define TMS_ASSERT_ALWAYS(lbl, cond)
`define TMS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: src/tms_pkg.sv
// Shared types, constants and arithmetic helpers of the matrix stack.
package tms_pkg;

    localparam int STACK_DEPTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int MATRIX_ENTRIES  = 16;
    localparam int ENTRY_BITS      = 4;
    localparam int CORDIC_STEPS    = 30;
    localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;
    localparam logic signed [31:0] RAD_TO_BAM      = 32'sd683565276;

    typedef enum logic [2:0] {
        CMD_RESET     = 3'd0,
        CMD_PUSH      = 3'd1,
        CMD_POP       = 3'd2,
        CMD_SCALE     = 3'd3,
        CMD_TRANSLATE = 3'd4,
        CMD_ROTATE    = 3'd5,
        CMD_READ      = 3'd6,
        CMD_NOP       = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_OVERFLOW = 2'd1,
        STAT_EMPTY    = 2'd2
    } status_t;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PUSH,
        ST_POP,
        ST_SCL_M,
        ST_SCL_A,
        ST_ANG_M,
        ST_ANG_A,
        ST_CORD,
        ST_MAT_M,
        ST_MAT_A,
        ST_RESP
    } state_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    // arctangent of 2^-i in binary-angle units (2^32 per turn)
    function automatic logic [29:0] atan_bam(input logic [4:0] i);
        case (i)
            5'd0:    return 30'h20000000;
            5'd1:    return 30'h12E4051E;
            5'd2:    return 30'h09FB385B;
            5'd3:    return 30'h051111D4;
            5'd4:    return 30'h028B0D43;
            5'd5:    return 30'h0145D7E1;
            5'd6:    return 30'h00A2F61E;
            5'd7:    return 30'h00517C55;
            5'd8:    return 30'h0028BE53;
            5'd9:    return 30'h00145F2F;
            5'd10:   return 30'h000A2F98;
            5'd11:   return 30'h000517CC;
            5'd12:   return 30'h00028BE6;
            5'd13:   return 30'h000145F3;
            5'd14:   return 30'h0000A2FA;
            5'd15:   return 30'h0000517D;
            5'd16:   return 30'h000028BE;
            5'd17:   return 30'h0000145F;
            5'd18:   return 30'h00000A30;
            5'd19:   return 30'h00000518;
            5'd20:   return 30'h0000028C;
            5'd21:   return 30'h00000146;
            5'd22:   return 30'h000000A3;
            5'd23:   return 30'h00000051;
            5'd24:   return 30'h00000029;
            5'd25:   return 30'h00000014;
            5'd26:   return 30'h0000000A;
            5'd27:   return 30'h00000005;
            5'd28:   return 30'h00000003;
            5'd29:   return 30'h00000001;
            default: return 30'h0;
        endcase
    endfunction

    // entry of the right-hand operand matrix (column-major index)
    function automatic logic signed [31:0] mat_entry(
        input logic [3:0]         idx,
        input cmd_t               cmd,
        input logic [1:0]         axis,
        input logic signed [31:0] ax,
        input logic signed [31:0] ay,
        input logic signed [31:0] az,
        input logic signed [31:0] sn,
        input logic signed [31:0] cs,
        input logic signed [31:0] one
    );
        logic signed [31:0] m;
        logic signed [31:0] nsn;
        nsn = sat32(-(64'(sn)));
        m = (idx == 4'd0 || idx == 4'd5 || idx == 4'd10 || idx == 4'd15) ? one : '0;
        if (cmd == CMD_TRANSLATE)
        begin
            case (idx)
                4'd12:   m = ax;
                4'd13:   m = ay;
                4'd14:   m = az;
                default: ;
            endcase
        end
        else if (cmd == CMD_ROTATE)
        begin
            case (axis)
                AXIS_X:
                begin
                    case (idx)
                        4'd5, 4'd10: m = cs;
                        4'd6:        m = sn;
                        4'd9:        m = nsn;
                        default:     ;
                    endcase
                end
                AXIS_Y:
                begin
                    case (idx)
                        4'd0, 4'd10: m = cs;
                        4'd8:        m = sn;
                        4'd2:        m = nsn;
                        default:     ;
                    endcase
                end
                default:
                begin
                    // Z, and the unused fourth code
                    case (idx)
                        4'd0, 4'd5: m = cs;
                        4'd1:       m = sn;
                        4'd4:       m = nsn;
                        default:    ;
                    endcase
                end
            endcase
        end
        return m;
    endfunction

endpackage

FILE: src/tms_ram.sv
// Generic single-port RAM with registered read.
module tms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem_reg[addr] <= wdata;
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/tms_cordic.sv
// Iterative rotation-mode CORDIC giving sine and cosine of a binary angle.
module tms_cordic #(
    parameter int FRAC_BITS = tms_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [31:0]        angle,
    output logic               done,
    output logic signed [31:0] sin_val,
    output logic signed [31:0] cos_val
);

    localparam int SH = 30 - FRAC_BITS;
    localparam logic signed [35:0] HALF = (36'sd1 <<< SH) >>> 1;

    logic               busy_reg;
    logic               done_reg;
    logic [4:0]         step_reg;
    logic signed [33:0] x_reg;
    logic signed [33:0] y_reg;
    logic signed [33:0] z_reg;
    logic               neg_reg;

    logic [31:0]        folded;
    logic               fold;
    logic signed [33:0] xs;
    logic signed [33:0] ys;
    logic signed [33:0] at;
    logic signed [35:0] rx;
    logic signed [35:0] ry;
    logic signed [35:0] cx;
    logic signed [35:0] cy;

    // fold the left half plane onto the right, negate afterwards
    always_comb
    begin
        fold   = (angle[31:30] == 2'b01) || (angle[31:30] == 2'b10);
        folded = fold ? (angle ^ 32'h80000000) : angle;
        xs     = x_reg >>> step_reg;
        ys     = y_reg >>> step_reg;
        at     = 34'(tms_pkg::atan_bam(step_reg));
        rx     = neg_reg ? -36'(x_reg) : 36'(x_reg);
        ry     = neg_reg ? -36'(y_reg) : 36'(y_reg);
        cx     = (rx + HALF) >>> SH;
        cy     = (ry + HALF) >>> SH;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (step_reg == 5'(tms_pkg::CORDIC_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                step_reg <= step_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= 34'(tms_pkg::CORDIC_GAIN_Q30);
            y_reg   <= '0;
            z_reg   <= 34'(signed'(folded));
            neg_reg <= fold;
        end
        else if (busy_reg)
        begin
            if (!z_reg[33])
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - at;
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + at;
            end
        end
    end

    assign done    = done_reg;
    assign cos_val = tms_pkg::sat32(64'(cx));
    assign sin_val = tms_pkg::sat32(64'(cy));

endmodule

FILE: src/transform_matrix_stack.sv
// Top level of the 4x4 fixed-point transform matrix stack.
//
// One command word is taken at a time; s_tready is high only while the block is
// idle, and a finished result may still wait on the output register while the
// next command is taken. Reset-identity, read, no-op and refused commands go
// straight to the response state; push makes one RAM write per entry, pop one
// RAM read per entry. The cost of the arithmetic commands is set by the single
// shared 32x32 multiplier, which spends a multiply state and an accumulate
// state on each product term (16 terms for scale, 64 for a matrix product, one
// for the angle conversion), plus the 30-step CORDIC for rotate.
// Matrices below the top live in a single-port RAM of STACK_DEPTH*16 words.
module transform_matrix_stack #(
    parameter int STACK_DEPTH = tms_pkg::STACK_DEPTH_DEF,
    parameter int FRAC_BITS   = tms_pkg::FRAC_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // arg_x[31:0], arg_y[63:32], arg_z[95:64], axis[97:96], element[101:98], zero pad
    input  logic [103:0] s_tdata,
    // command[2:0]
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // stack_depth[5:0], value[37:6], zero pad
    output logic [39:0]  m_tdata,
    // status[1:0]
    output logic [1:0]   m_tuser
);

    `include "transform_matrix_stack_defines.svh"

    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int SW = $clog2(STACK_DEPTH);
    localparam int AW = SW + tms_pkg::ENTRY_BITS;
    localparam logic signed [31:0] ONE_Q = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [63:0] HALF  = 64'sd1 <<< (FRAC_BITS - 1);

    tms_pkg::state_t state_reg, state_next;

    logic [DW-1:0]      depth_reg;
    logic [5:0]         cnt_reg;
    logic signed [31:0] top_reg [tms_pkg::MATRIX_ENTRIES];
    logic               m_tvalid_reg;

    tms_pkg::cmd_t      cmd_reg;
    logic signed [31:0] ax_reg;
    logic signed [31:0] ay_reg;
    logic signed [31:0] az_reg;
    logic [1:0]         axis_reg;
    logic signed [63:0] prod_reg;
    logic signed [63:0] acc_reg;
    logic signed [31:0] tmp_reg [3];
    logic signed [31:0] sin_reg;
    logic signed [31:0] cos_reg;
    tms_pkg::status_t   resp_status_reg;
    logic signed [31:0] resp_value_reg;
    logic [1:0]         out_status_reg;
    logic [5:0]         out_depth_reg;
    logic [31:0]        out_value_reg;

    tms_pkg::cmd_t      s_cmd;
    logic               accept;
    logic               resp_fire;
    logic               empty;
    logic               full;
    logic [DW-1:0]      depth_m1;
    logic [3:0]         top_idx;
    logic signed [31:0] top_rd;
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [63:0] term;
    logic signed [63:0] acc_sum;
    logic [1:0]         row;
    logic [1:0]         col;
    logic [1:0]         kk;
    logic               ram_we;
    logic [AW-1:0]      ram_addr;
    logic [31:0]        ram_rdata;
    logic               cordic_start;
    logic               cordic_done;
    logic signed [31:0] cordic_sin;
    logic signed [31:0] cordic_cos;

    assign s_cmd     = tms_pkg::cmd_t'(s_tuser);
    assign s_tready  = (state_reg == tms_pkg::ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign resp_fire = (state_reg == tms_pkg::ST_RESP) && (!m_tvalid_reg || m_tready);
    assign empty     = (depth_reg == '0);
    assign full      = (depth_reg >= DW'(STACK_DEPTH));
    assign depth_m1  = depth_reg - DW'(1);
    assign row       = cnt_reg[5:4];
    assign col       = cnt_reg[3:2];
    assign kk        = cnt_reg[1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tms_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_cmd == tms_pkg::CMD_RESET || s_cmd == tms_pkg::CMD_NOP || empty)
                        state_next = tms_pkg::ST_RESP;
                    else
                    begin
                        case (s_cmd)
                            tms_pkg::CMD_PUSH:
                                state_next = full ? tms_pkg::ST_RESP : tms_pkg::ST_PUSH;
                            tms_pkg::CMD_POP:
                                state_next = (depth_reg == DW'(1)) ? tms_pkg::ST_RESP
                                                                   : tms_pkg::ST_POP;
                            tms_pkg::CMD_SCALE:     state_next = tms_pkg::ST_SCL_M;
                            tms_pkg::CMD_TRANSLATE: state_next = tms_pkg::ST_MAT_M;
                            tms_pkg::CMD_ROTATE:    state_next = tms_pkg::ST_ANG_M;
                            default:                state_next = tms_pkg::ST_RESP;
                        endcase
                    end
                end
            end
            tms_pkg::ST_PUSH:
                if (cnt_reg[3:0] == 4'd15)
                    state_next = tms_pkg::ST_RESP;
            tms_pkg::ST_POP:
                if (cnt_reg[4])
                    state_next = tms_pkg::ST_RESP;
            tms_pkg::ST_SCL_M:
                state_next = tms_pkg::ST_SCL_A;
            tms_pkg::ST_SCL_A:
                state_next = (cnt_reg[3:0] == 4'd15) ? tms_pkg::ST_RESP : tms_pkg::ST_SCL_M;
            tms_pkg::ST_ANG_M:
                state_next = tms_pkg::ST_ANG_A;
            tms_pkg::ST_ANG_A:
                state_next = tms_pkg::ST_CORD;
            tms_pkg::ST_CORD:
                if (cordic_done)
                    state_next = tms_pkg::ST_MAT_M;
            tms_pkg::ST_MAT_M:
                state_next = tms_pkg::ST_MAT_A;
            tms_pkg::ST_MAT_A:
                state_next = (cnt_reg == 6'd63) ? tms_pkg::ST_RESP : tms_pkg::ST_MAT_M;
            tms_pkg::ST_RESP:
                if (resp_fire)
                    state_next = tms_pkg::ST_IDLE;
            default:
                state_next = tms_pkg::ST_IDLE;
        endcase
    end

    // datapath controls
    always_comb
    begin
        top_idx      = cnt_reg[3:0];
        mul_a        = top_rd;
        mul_b        = ax_reg;
        ram_we       = 1'b0;
        cordic_start = 1'b0;
        ram_addr     = {depth_m1[SW-1:0], cnt_reg[3:0]};
        unique case (state_reg)
            tms_pkg::ST_IDLE:
                top_idx = s_tdata[101:98];
            tms_pkg::ST_PUSH:
                ram_we = 1'b1;
            tms_pkg::ST_ANG_M:
            begin
                mul_a = ax_reg;
                mul_b = tms_pkg::RAD_TO_BAM;
            end
            tms_pkg::ST_ANG_A:
                cordic_start = 1'b1;
            tms_pkg::ST_MAT_M:
            begin
                // top entry (row, k) times operand entry (k, col)
                top_idx = {kk, row};
                mul_b   = tms_pkg::mat_entry({col, kk}, cmd_reg, axis_reg, ax_reg, ay_reg,
                                             az_reg, sin_reg, cos_reg, ONE_Q);
            end
            default: ;
        endcase
    end

    assign top_rd  = top_reg[top_idx];
    assign term    = (prod_reg + HALF) >>> FRAC_BITS;
    assign acc_sum = acc_reg + term;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= tms_pkg::ST_IDLE;
            cnt_reg      <= '0;
            depth_reg    <= DW'(1);
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < tms_pkg::MATRIX_ENTRIES; i++)
                top_reg[i] <= (i % 5 == 0) ? ONE_Q : '0;
        end
        else
        begin
            state_reg <= state_next;
            if (resp_fire)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;

            case (state_reg)
                tms_pkg::ST_IDLE:
                begin
                    cnt_reg <= '0;
                    if (accept)
                    begin
                        if (s_cmd == tms_pkg::CMD_RESET)
                        begin
                            depth_reg <= DW'(1);
                            for (int i = 0; i < tms_pkg::MATRIX_ENTRIES; i++)
                                top_reg[i] <= (i % 5 == 0) ? ONE_Q : '0;
                        end
                        else if (s_cmd == tms_pkg::CMD_POP && !empty)
                            depth_reg <= depth_m1;
                    end
                end
                tms_pkg::ST_PUSH:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg[3:0] == 4'd15)
                        depth_reg <= depth_reg + DW'(1);
                end
                tms_pkg::ST_POP:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg != '0)
                        top_reg[4'(cnt_reg - 6'd1)] <= ram_rdata;
                end
                tms_pkg::ST_SCL_A:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    top_reg[cnt_reg[3:0]] <= tms_pkg::sat32(term);
                end
                tms_pkg::ST_MAT_A:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    // a finished row only feeds itself, so write it back in place
                    if (kk == 2'd3 && col == 2'd3)
                    begin
                        top_reg[{2'd0, row}] <= tmp_reg[0];
                        top_reg[{2'd1, row}] <= tmp_reg[1];
                        top_reg[{2'd2, row}] <= tmp_reg[2];
                        top_reg[{2'd3, row}] <= tms_pkg::sat32(acc_sum);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (accept)
        begin
            cmd_reg         <= s_cmd;
            ax_reg          <= s_tdata[31:0];
            ay_reg          <= s_tdata[63:32];
            az_reg          <= s_tdata[95:64];
            axis_reg        <= s_tdata[97:96];
            acc_reg         <= '0;
            resp_value_reg  <= '0;
            resp_status_reg <= tms_pkg::STAT_OK;
            if (s_cmd != tms_pkg::CMD_RESET && s_cmd != tms_pkg::CMD_NOP && empty)
                resp_status_reg <= tms_pkg::STAT_EMPTY;
            else if (s_cmd == tms_pkg::CMD_PUSH && full)
                resp_status_reg <= tms_pkg::STAT_OVERFLOW;
            else if (s_cmd == tms_pkg::CMD_READ)
                resp_value_reg <= top_rd;
        end
        if (state_reg == tms_pkg::ST_CORD && cordic_done)
        begin
            sin_reg <= cordic_sin;
            cos_reg <= cordic_cos;
        end
        if (state_reg == tms_pkg::ST_MAT_A)
        begin
            if (kk == 2'd3)
            begin
                acc_reg <= '0;
                if (col != 2'd3)
                    tmp_reg[col] <= tms_pkg::sat32(acc_sum);
            end
            else
                acc_reg <= acc_sum;
        end
        if (resp_fire)
        begin
            out_status_reg <= resp_status_reg;
            out_depth_reg  <= 6'(depth_reg);
            out_value_reg  <= resp_value_reg;
        end
    end

    tms_ram #(
        .WIDTH(32),
        .DEPTH(STACK_DEPTH * tms_pkg::MATRIX_ENTRIES)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(top_rd),
        .rdata(ram_rdata)
    );

    tms_cordic #(
        .FRAC_BITS(FRAC_BITS)
    ) u_cordic (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cordic_start),
        .angle  (term[31:0]),
        .done   (cordic_done),
        .sin_val(cordic_sin),
        .cos_val(cordic_cos)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, out_value_reg, out_depth_reg};
    assign m_tuser  = out_status_reg;

    `TMS_ASSERT_ALWAYS(a_depth_bound, depth_reg <= DW'(STACK_DEPTH))
    `TMS_ASSERT_ALWAYS(a_store_room, !ram_we || (!empty && !full))
    `TMS_ASSERT_ALWAYS(a_cordic_in_wait, !cordic_done || state_reg == tms_pkg::ST_CORD)
    `TMS_ASSERT_NEXT(a_busy_after_take, accept, !s_tready)

endmodule

FILE: dv/tms_checker.sv
// Checker for the matrix stack: predicts each result word and compares.
module tms_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [103:0] s_tdata,
    input  logic [2:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [39:0]  m_tdata,
    input  logic [1:0]   m_tuser,
    output int           fail_count,
    output int           pending
);

    localparam int DEPTH = tms_pkg::STACK_DEPTH_DEF;
    localparam int FRAC  = tms_pkg::FRAC_BITS_DEF;

    typedef struct packed {
        logic [1:0]         status;
        logic [5:0]         depth;
        logic signed [31:0] value;
    } result_t;

    result_t            expected_q[$];
    logic signed [31:0] top_m[16];
    logic signed [31:0] saved_m[DEPTH][16];
    int unsigned        depth_cnt;

    function automatic logic signed [63:0] fshift(input logic signed [63:0] v, input int n);
        return v >>> n;
    endfunction

    function automatic logic signed [63:0] rshift(input logic signed [63:0] v, input int n);
        if (n == 0)
            return v;
        return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic logic signed [31:0] clip32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [63:0] arctan(input int i);
        logic signed [63:0] t[30];
        t = '{64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
              64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
              64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
              64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
              64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
              64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001};
        return t[i];
    endfunction

    task automatic sine_cosine(input logic signed [31:0] ang,
                               output logic signed [31:0] sn, output logic signed [31:0] cs);
        logic signed [63:0] p, x, y, z, xs, ys;
        logic [63:0]        up;
        logic [31:0]        b;
        logic               flip;
        p = 64'(ang) * 64'sd683565276;
        up = p + (64'd1 << (FRAC - 1));
        b = up[FRAC +: 32];
        flip = (b[31:30] == 2'd1) || (b[31:30] == 2'd2);
        if (flip)
            b = b - 32'h80000000;
        z = 64'(signed'(b));
        x = 64'sd652032874;
        y = 0;
        for (int i = 0; i < 30; i++)
        begin
            xs = fshift(x, i);
            ys = fshift(y, i);
            if (z >= 0)
            begin
                x = x - ys; y = y + xs; z = z - arctan(i);
            end
            else
            begin
                x = x + ys; y = y - xs; z = z + arctan(i);
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        cs = clip32(rshift(x, 30 - FRAC));
        sn = clip32(rshift(y, 30 - FRAC));
    endtask

    task automatic load_identity(output logic signed [31:0] m[16]);
        for (int i = 0; i < 16; i++)
            m[i] = (i % 5 == 0) ? 32'sd1 <<< FRAC : 32'sd0;
    endtask

    task automatic post_mult(input logic signed [31:0] m[16]);
        logic signed [31:0] nxt[16];
        logic signed [63:0] acc;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
            begin
                acc = 0;
                for (int k = 0; k < 4; k++)
                    acc = acc + rshift(64'(top_m[r + 4 * k]) * 64'(m[k + 4 * c]), FRAC);
                nxt[r + 4 * c] = clip32(acc);
            end
        top_m = nxt;
    endtask

    task automatic predict(input tms_pkg::cmd_t cmd, input logic [103:0] d);
        logic signed [31:0] ax, ay, az, sn, cs;
        logic signed [31:0] m[16];
        logic [1:0]         axis;
        logic [3:0]         elem;
        result_t            r;
        ax = d[31:0];
        ay = d[63:32];
        az = d[95:64];
        axis = d[97:96];
        elem = d[101:98];
        r.status = tms_pkg::STAT_OK;
        r.value = 0;
        if (cmd == tms_pkg::CMD_RESET)
        begin
            depth_cnt = 1;
            load_identity(top_m);
        end
        else if (cmd != tms_pkg::CMD_NOP && depth_cnt == 0)
            r.status = tms_pkg::STAT_EMPTY;
        else if (cmd == tms_pkg::CMD_PUSH)
        begin
            if (depth_cnt >= DEPTH)
                r.status = tms_pkg::STAT_OVERFLOW;
            else
            begin
                saved_m[depth_cnt - 1] = top_m;
                depth_cnt++;
            end
        end
        else if (cmd == tms_pkg::CMD_POP)
        begin
            depth_cnt--;
            if (depth_cnt > 0)
                top_m = saved_m[depth_cnt - 1];
        end
        else if (cmd == tms_pkg::CMD_SCALE)
        begin
            for (int i = 0; i < 16; i++)
                top_m[i] = clip32(rshift(64'(top_m[i]) * 64'(ax), FRAC));
        end
        else if (cmd == tms_pkg::CMD_TRANSLATE)
        begin
            load_identity(m);
            m[12] = ax; m[13] = ay; m[14] = az;
            post_mult(m);
        end
        else if (cmd == tms_pkg::CMD_ROTATE)
        begin
            sine_cosine(ax, sn, cs);
            load_identity(m);
            if (axis == tms_pkg::AXIS_X)
            begin
                m[5] = cs; m[6] = sn; m[9] = clip32(-64'(sn)); m[10] = cs;
            end
            else if (axis == tms_pkg::AXIS_Y)
            begin
                m[0] = cs; m[8] = sn; m[2] = clip32(-64'(sn)); m[10] = cs;
            end
            else
            begin
                m[0] = cs; m[1] = sn; m[4] = clip32(-64'(sn)); m[5] = cs;
            end
            post_mult(m);
        end
        else if (cmd == tms_pkg::CMD_READ)
            r.value = top_m[elem];
        r.depth = depth_cnt[5:0];
        expected_q.push_back(r);
    endtask

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            fail_count <= 0;
            depth_cnt = 1;
            load_identity(top_m);
            expected_q.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result word with nothing expected");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (m_tuser !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, m_tuser);
                        fail_count <= fail_count + 1;
                    end
                    if (m_tdata[5:0] !== want.depth)
                    begin
                        $error("stack_depth: expected %0d, got %0d", want.depth, m_tdata[5:0]);
                        fail_count <= fail_count + 1;
                    end
                    if (m_tdata[37:6] !== want.value)
                    begin
                        $error("value: expected %0d, got %0d", want.value,
                               $signed(m_tdata[37:6]));
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_tvalid && s_tready)
                predict(tms_pkg::cmd_t'(s_tuser), s_tdata);
        end
    end

endmodule

FILE: dv/tb_transform_matrix_stack.sv
// Stimulus and verdict for the matrix stack testbench.
module tb_transform_matrix_stack;

    logic         clk = 0;
    logic         rst_n = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [103:0] s_tdata = '0;
    logic [2:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [39:0]  m_tdata;
    logic [1:0]   m_tuser;
    int           fail_count;
    int           pending;
    bit           calm = 0;

    always
    begin
        #2 clk = 1;
        #2 clk = 0;
    end

    transform_matrix_stack dut (.*);

    tms_checker chk (.*);

    always @(posedge clk)
        m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 17);

    function automatic logic [31:0] rand_arg();
        case ($urandom_range(7))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h00010000;
            3: return 32'($signed($urandom_range(8192)) - 4096);
            4: return $urandom;
            default: return 32'($signed($urandom_range(262144)) - 131072);
        endcase
    endfunction

    // tvalid stays high between back-to-back words and drops only while idling
    task automatic send(input tms_pkg::cmd_t cmd, input logic [31:0] ax,
                        input logic [31:0] ay, input logic [31:0] az,
                        input logic [1:0] axis, input logic [3:0] elem);
        while (!calm && $urandom_range(99) < 17)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {2'b0, elem, axis, az, ay, ax};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic send_random();
        int            k;
        tms_pkg::cmd_t c;
        k = $urandom_range(99);
        if (k < 8) c = tms_pkg::CMD_RESET;
        else if (k < 26) c = tms_pkg::CMD_PUSH;
        else if (k < 42) c = tms_pkg::CMD_POP;
        else if (k < 52) c = tms_pkg::CMD_SCALE;
        else if (k < 64) c = tms_pkg::CMD_TRANSLATE;
        else if (k < 78) c = tms_pkg::CMD_ROTATE;
        else if (k < 97) c = tms_pkg::CMD_READ;
        else c = tms_pkg::CMD_NOP;
        send(c, rand_arg(), rand_arg(), rand_arg(), 2'($urandom_range(3)),
             4'($urandom_range(15)));
    endtask

    initial
    begin
        #400000000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        int drain;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // directed: reads of identity, extremes, empty stack, overflow, axis codes
        send(tms_pkg::CMD_READ, '0, '0, '0, '0, '0);
        send(tms_pkg::CMD_READ, '0, '0, '0, '0, 4'd15);
        send(tms_pkg::CMD_SCALE, 32'h7fffffff, '0, '0, '0, '0);
        send(tms_pkg::CMD_READ, '0, '0, '0, '0, 4'd5);
        send(tms_pkg::CMD_TRANSLATE, 32'h80000000, 32'h7fffffff, 32'hffffffff, '0, '0);
        send(tms_pkg::CMD_READ, '0, '0, '0, '0, 4'd12);
        send(tms_pkg::CMD_RESET, '1, '1, '1, 2'd3, 4'd15);
        send(tms_pkg::CMD_ROTATE, 32'h0001921f, '0, '0, tms_pkg::AXIS_X, '0);
        send(tms_pkg::CMD_ROTATE, 32'h80000000, '0, '0, tms_pkg::AXIS_Y, '0);
        send(tms_pkg::CMD_ROTATE, 32'h7fffffff, '0, '0, 2'd2, '0);
        send(tms_pkg::CMD_ROTATE, 32'h00032000, '0, '0, 2'd3, '0);
        send(tms_pkg::CMD_READ, '0, '0, '0, '0, 4'd1);
        send(tms_pkg::CMD_POP, '0, '0, '0, '0, '0);
        send(tms_pkg::CMD_POP, '0, '0, '0, '0, '0);
        send(tms_pkg::CMD_PUSH, '0, '0, '0, '0, '0);
        send(tms_pkg::CMD_SCALE, 32'd1, '0, '0, '0, '0);
        send(tms_pkg::CMD_ROTATE, 32'd1, '0, '0, '0, '0);
        send(tms_pkg::CMD_READ, '0, '0, '0, '0, 4'd3);
        send(tms_pkg::CMD_NOP, '0, '0, '0, '0, '0);
        send(tms_pkg::CMD_RESET, '0, '0, '0, '0, '0);
        for (int i = 0; i < 33; i++)
            send(tms_pkg::CMD_PUSH, '0, '0, '0, '0, '0);
        for (int i = 0; i < 32; i++)
            send(tms_pkg::CMD_POP, '0, '0, '0, '0, '0);
        send(tms_pkg::CMD_RESET, '0, '0, '0, '0, '0);
        // sender holds off until the block has drained
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        for (int i = 0; i < 1000; i++)
        begin
            calm = (i >= 400 && i < 550);
            send_random();
        end
        s_tvalid <= 1'b0;
        calm = 0;
        drain = 0;
        while (pending != 0 && drain < 100000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (300) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
